// ----- rtl/hnsr_pkg.sv -----
// Package with shared constants, types and the helper function of the set replacement block.
`timescale 1ns / 1ps
package hnsr_pkg;

  localparam int LIMIT_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int FIELD_TAG_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NVM_HIGH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NVM_LOW  = 1'd1;

  localparam logic [LIMIT_W-1:0] NVM_HIGH_RESET = 5'd12;
  localparam logic [LIMIT_W-1:0] NVM_LOW_RESET  = 5'd4;

  typedef struct packed {
    logic load;
    logic look;
    logic update;
  } hnsr_cmd_t;

  typedef struct packed {
    logic out_free;
  } hnsr_status_t;

  // Index of the lowest set bit, zero when none is set.
  function automatic logic [4:0] first_set(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- rtl/hnsr_req_if.sv -----
// Request channel interface carrying one access per beat.
`timescale 1ns / 1ps
interface hnsr_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_tag;
  logic        block_is_nvm;
  logic        block_dirty;
  logic        block_chance;

  modport source (output valid, block_tag, block_is_nvm, block_dirty, block_chance,
                  input ready);
  modport sink (input valid, block_tag, block_is_nvm, block_dirty, block_chance,
                output ready);
endinterface

// ----- rtl/hnsr_rsp_if.sv -----
// Response channel interface carrying one result per beat.
`timescale 1ns / 1ps
interface hnsr_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        evicted_valid;
  logic [31:0] evicted_tag;
  logic        evicted_is_nvm;
  logic        dirty_eviction;

  modport source (output valid, hit, evicted_valid, evicted_tag, evicted_is_nvm,
                  dirty_eviction, input ready);
  modport sink (input valid, hit, evicted_valid, evicted_tag, evicted_is_nvm,
                dirty_eviction, output ready);
endinterface

// ----- rtl/hnsr_ctrl.sv -----
// Controller state machine sequencing capture, lookup and update of one access.
`timescale 1ns / 1ps
module hnsr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  hnsr_pkg::hnsr_status_t status,
  output hnsr_pkg::hnsr_cmd_t    cmd
);
  import hnsr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        // The set is only rewritten once the result register can take the beat.
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ----- rtl/hnsr_dp.sv -----
// Datapath: recency-ordered way entries, victim selection, counters and result register.
`timescale 1ns / 1ps
module hnsr_dp #(
  parameter int WAYS = 16,
  parameter int TAG_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [hnsr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hnsr_pkg::LIMIT_W-1:0]          cfg_data,
  input  logic [31:0]                          in_tag,
  input  logic                                 in_nvm,
  input  logic                                 in_dirty,
  input  logic                                 in_chance,
  input  hnsr_pkg::hnsr_cmd_t                   cmd,
  output hnsr_pkg::hnsr_status_t                status,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_hit,
  output logic                                 out_evicted_valid,
  output logic [31:0]                          out_evicted_tag,
  output logic                                 out_evicted_is_nvm,
  output logic                                 out_dirty_eviction
);
  import hnsr_pkg::*;

  localparam int CW = $clog2(WAYS + 1);
  localparam int IW = $clog2(WAYS);

  logic [TAG_BITS-1:0] tag_q [WAYS];
  logic [WAYS-1:0]     nvm_q, dirty_q, chance_q;
  logic [CW-1:0]       occ, nvm_cnt;
  logic [LIMIT_W-1:0]  hi_lim, lo_lim;

  logic [TAG_BITS-1:0] nb_tag;
  logic                nb_nvm, nb_dirty, nb_chance;

  logic          rm, hit_r, evict_r;
  logic [IW-1:0] pos;
  logic [WAYS-1:0] clr_mask;

  logic [63:0] tag_in64;
  assign tag_in64 = {32'b0, in_tag};

  // Lookup and victim choice.
  logic [WAYS-1:0] valid_v, match_v, skip_v, cand, nonskip, below, clr_c;
  logic            hit_c, full, nvm_mode, dram_mode, use_nvm, use_dram, found_ns;
  logic [IW-1:0]   hit_idx, ns_idx, cand_idx, victim;
  logic [6:0]      cnt7;

  assign full = (occ == CW'(WAYS));
  assign cnt7 = 7'(nvm_cnt);
  assign nvm_mode  = (cnt7 > 7'(hi_lim)) && nb_nvm;
  assign dram_mode = (cnt7 < 7'(lo_lim)) && !nb_nvm;

  for (genvar i = 0; i < WAYS; i++) begin : g_look
    assign valid_v[i] = (CW'(i) < occ);
    assign match_v[i] = valid_v[i] && (tag_q[i] == nb_tag);
    assign skip_v[i]  = nvm_q[i] && dirty_q[i] && chance_q[i];
    assign below[i]   = !found_ns || (IW'(i) < ns_idx);
  end

  assign hit_c    = |match_v;
  assign use_nvm  = nvm_mode && |(valid_v & nvm_q);
  assign use_dram = dram_mode && |(valid_v & ~nvm_q);
  assign cand     = use_dram ? (valid_v & ~nvm_q) : (use_nvm ? (valid_v & nvm_q) : valid_v);
  assign nonskip  = use_dram ? cand : (cand & ~skip_v);
  assign found_ns = |nonskip;

  logic [4:0] hit_idx5, ns_idx5, cand_idx5;
  assign hit_idx5  = first_set(32'(match_v));
  assign ns_idx5   = first_set(32'(nonskip));
  assign cand_idx5 = first_set(32'(cand));
  assign hit_idx   = hit_idx5[IW-1:0];
  assign ns_idx    = ns_idx5[IW-1:0];
  assign cand_idx  = cand_idx5[IW-1:0];
  assign victim    = found_ns ? ns_idx : cand_idx;

  // Skipped dirty NVM entries lose their second chance.
  assign clr_c = use_dram ? '0 : (cand & skip_v & below);

  // Update: remove at pos, shift the younger entries down, append at MRU.
  logic [WAYS-1:0]     chance_clr;
  logic [CW-1:0]       wr, wr_occ;
  logic [TAG_BITS-1:0] tag_n [WAYS];
  logic [WAYS-1:0]     nvm_n, dirty_n, chance_n;
  logic                rm_nvm;

  assign chance_clr = chance_q & ~clr_mask;
  assign wr     = rm ? (occ - CW'(1)) : occ;
  assign wr_occ = wr + CW'(1);
  assign rm_nvm = rm && nvm_q[pos] && (nvm_cnt != '0);

  for (genvar i = 0; i < WAYS; i++) begin : g_upd
    logic shift;
    if (i < WAYS - 1) begin : g_sh
      assign shift = rm && (IW'(i) >= pos);
    end else begin : g_nosh
      assign shift = 1'b0;
    end
    always_comb begin
      if (CW'(i) == wr) begin
        tag_n[i] = nb_tag;
        nvm_n[i] = nb_nvm;
        dirty_n[i] = nb_dirty;
        chance_n[i] = nb_chance;
      end else if (shift) begin
        tag_n[i] = tag_q[(i + 1) % WAYS];
        nvm_n[i] = nvm_q[(i + 1) % WAYS];
        dirty_n[i] = dirty_q[(i + 1) % WAYS];
        chance_n[i] = chance_clr[(i + 1) % WAYS];
      end else begin
        tag_n[i] = tag_q[i];
        nvm_n[i] = nvm_q[i];
        dirty_n[i] = dirty_q[i];
        chance_n[i] = chance_clr[i];
      end
    end
  end

  logic [63:0] ev_tag64;
  assign ev_tag64 = 64'(tag_q[pos]);

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nb_tag    <= tag_in64[TAG_BITS-1:0];
      nb_nvm    <= in_nvm;
      nb_dirty  <= in_dirty;
      nb_chance <= in_chance;
    end
    if (cmd.look) begin
      hit_r    <= hit_c;
      evict_r  <= !hit_c && full;
      rm       <= hit_c || full;
      pos      <= hit_c ? hit_idx : victim;
      clr_mask <= hit_c ? '0 : (full ? clr_c : '0);
    end
    if (cmd.update) begin
      for (int i = 0; i < WAYS; i++) begin
        tag_q[i] <= tag_n[i];
      end
      nvm_q    <= nvm_n;
      dirty_q  <= dirty_n;
      chance_q <= chance_n;
      out_hit            <= hit_r;
      out_evicted_valid  <= evict_r;
      out_evicted_tag    <= evict_r ? ev_tag64[31:0] : 32'd0;
      out_evicted_is_nvm <= evict_r && nvm_q[pos];
      out_dirty_eviction <= evict_r && dirty_q[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      nvm_cnt   <= '0;
      hi_lim    <= NVM_HIGH_RESET;
      lo_lim    <= NVM_LOW_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NVM_HIGH: hi_lim <= cfg_data;
          REG_NVM_LOW:  lo_lim <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.update) begin
        occ       <= wr_occ;
        nvm_cnt   <= nvm_cnt - CW'(rm_nvm) + CW'(nb_nvm);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// ----- rtl/hybrid_nvm_dram_set_replacement.sv -----
// Top level of one hybrid NVM/DRAM cache set with partitioned LRU replacement.
//
//  channel | dir | handshake       | beat contents
//  req     | in  | valid / ready   | block_tag, block_is_nvm, block_dirty, block_chance
//  rsp     | out | valid / ready   | hit, evicted_valid, evicted_tag, evicted_is_nvm,
//          |     |                 | dirty_eviction
//  cfg     | in  | cfg_we only     | cfg_index, cfg_data (nvm_high_limit, nvm_low_limit)
//
// Each access takes three steps: capture, tag match and victim choice across all ways,
// then the recency shift and write of the set. The next access is taken the cycle after.
// The result sits in an output register; a stalled rsp holds only the final update.
// Synchronous reset empties the set and restores the limits to 12 and 4.
`timescale 1ns / 1ps
module hybrid_nvm_dram_set_replacement #(
  parameter int WAYS = 16,
  parameter int TAG_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hnsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hnsr_pkg::LIMIT_W-1:0]     cfg_data,
  hnsr_req_if.sink                        req,
  hnsr_rsp_if.source                      rsp
);
  import hnsr_pkg::*;

  hnsr_cmd_t    cmd;
  hnsr_status_t status;

  hnsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  hnsr_dp #(
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_tag             (req.block_tag),
    .in_nvm             (req.block_is_nvm),
    .in_dirty           (req.block_dirty),
    .in_chance          (req.block_chance),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (rsp.valid),
    .out_ready          (rsp.ready),
    .out_hit            (rsp.hit),
    .out_evicted_valid  (rsp.evicted_valid),
    .out_evicted_tag    (rsp.evicted_tag),
    .out_evicted_is_nvm (rsp.evicted_is_nvm),
    .out_dirty_eviction (rsp.dirty_eviction)
  );
endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for one hybrid NVM/DRAM cache set with partitioned LRU replacement.
`timescale 1ns / 1ps
module tb;
  import hnsr_pkg::*;

  localparam int SET_WAYS = 16;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic [31:0] tag;
    logic        nvm;
    logic        dirty;
    logic        chance;
  } way_t;

  typedef struct packed {
    logic        hit;
    logic        ev_valid;
    logic [31:0] ev_tag;
    logic        ev_nvm;
    logic        ev_dirty;
  } outcome_t;

  typedef struct packed {
    way_t     acc;
    logic     typed;
    outcome_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NVM_HIGH;
  logic [LIMIT_W-1:0] cfg_data = '0;

  hnsr_req_if req ();
  hnsr_rsp_if rsp ();

  initial begin
    req.valid = 1'b0;
    req.block_tag = '0;
    req.block_is_nvm = 1'b0;
    req.block_dirty = 1'b0;
    req.block_chance = 1'b0;
    rsp.ready = 1'b0;
  end

  hybrid_nvm_dram_set_replacement dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the set: entry 0 is least recently used.
  way_t set_q[$];
  int unsigned nvm_cnt;
  logic [LIMIT_W-1:0] high_lim = NVM_HIGH_RESET;
  logic [LIMIT_W-1:0] low_lim = NVM_LOW_RESET;

  outcome_t pending_q[$];
  row_t directed_q[$];
  int errors = 0;
  int n_acc = 0, n_res = 0, n_hit = 0, n_evict = 0, n_dirty_ev = 0;
  int idle_cnt = 0;
  bit quiet = 1'b0;

  // Second-chance scan: dirty NVM entries with chance set lose it and are passed over.
  function automatic int chance_scan(bit only_nvm);
    int first;
    first = -1;
    for (int i = 0; i < set_q.size(); i++) begin
      if (only_nvm && !set_q[i].nvm) continue;
      if (first < 0) first = i;
      if (set_q[i].nvm && set_q[i].dirty && set_q[i].chance) begin
        set_q[i].chance = 1'b0;
        continue;
      end
      return i;
    end
    return first;
  endfunction

  function automatic outcome_t replace_access(way_t nb);
    outcome_t r;
    int victim;
    r = '0;
    victim = -1;
    for (int i = 0; i < set_q.size(); i++) begin
      if (set_q[i].tag == nb.tag) begin
        if (set_q[i].nvm && nvm_cnt > 0) nvm_cnt--;
        set_q.delete(i);
        set_q.insert(set_q.size(), nb);
        if (nb.nvm) nvm_cnt++;
        r.hit = 1'b1;
        return r;
      end
    end
    if (set_q.size() >= SET_WAYS) begin
      if (nvm_cnt > high_lim && nb.nvm) begin
        victim = chance_scan(1'b1);
      end else if (nvm_cnt < low_lim && !nb.nvm) begin
        for (int i = 0; i < set_q.size(); i++) begin
          if (!set_q[i].nvm) begin
            victim = i;
            break;
          end
        end
      end
      if (victim < 0) victim = chance_scan(1'b0);
      if (victim >= 0) begin
        r.ev_valid = 1'b1;
        r.ev_tag = set_q[victim].tag;
        r.ev_nvm = set_q[victim].nvm;
        r.ev_dirty = set_q[victim].dirty;
        if (set_q[victim].nvm && nvm_cnt > 0) nvm_cnt--;
        set_q.delete(victim);
      end
    end
    if (set_q.size() < SET_WAYS) begin
      set_q.insert(set_q.size(), nb);
      if (nb.nvm) nvm_cnt++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    way_t a;
    outcome_t p, got;
    row_t d;
    if (!rst) begin
      if (req.valid && req.ready) begin
        a = {req.block_tag, req.block_is_nvm, req.block_dirty, req.block_chance};
        p = replace_access(a);
        if (directed_q.size() > 0) begin
          d = directed_q.pop_front();
          if (d.typed) p = d.want;
        end
        pending_q.insert(pending_q.size(), p);
        n_acc++;
      end
      if (rsp.valid && rsp.ready) begin
        got = {rsp.hit, rsp.evicted_valid, rsp.evicted_tag, rsp.evicted_is_nvm,
               rsp.dirty_eviction};
        n_res++;
        if (got.hit) n_hit++;
        if (got.ev_valid) n_evict++;
        if (got.ev_dirty) n_dirty_ev++;
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected result beat %p", got);
        end else begin
          p = pending_q.pop_front();
          if (got !== p) begin
            errors++;
            if (errors <= 10)
              $display({"ERROR: result %0d: expected hit=%b ev=%b tag=%h nvm=%b dirty=%b,",
                        " got hit=%b ev=%b tag=%h nvm=%b dirty=%b"},
                       n_res, p.hit, p.ev_valid, p.ev_tag, p.ev_nvm, p.ev_dirty,
                       got.hit, got.ev_valid, got.ev_tag, got.ev_nvm, got.ev_dirty);
          end
        end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
        idle_cnt = 0;
      else
        idle_cnt++;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver: alternating ready runs and stall bursts, steady once the run goes quiet.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (quiet) begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 30);
        rsp.ready <= 1'b1;
        repeat (n) @(posedge clk);
        n = $urandom_range(1, 14);
        rsp.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send(way_t a);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.block_tag <= a.tag;
    req.block_is_nvm <= a.nvm;
    req.block_dirty <= a.dirty;
    req.block_chance <= a.chance;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic set_limit(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
    req.valid <= 1'b0;
    // Wait on a clock edge first so the last accepted beat is already queued.
    @(posedge clk);
    wait (pending_q.size() == 0);
    @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NVM_HIGH) high_lim = val;
    else low_lim = val;
  endtask

  logic [31:0] tag_pool[24];

  function automatic way_t pick_access();
    way_t a;
    if ($urandom_range(0, 9) == 0) a.tag = $urandom();
    else a.tag = tag_pool[$urandom_range(0, 23)];
    a.nvm = $urandom_range(0, 1);
    a.dirty = $urandom_range(0, 1);
    a.chance = $urandom_range(0, 1);
    return a;
  endfunction

  initial begin
    row_t rows[$];
    row_t r;
    outcome_t miss, hit1;
    miss = '0;
    hit1 = '0;
    hit1.hit = 1'b1;
    // Fill the empty set: sixteen misses, none evicts.
    for (int i = 0; i < SET_WAYS; i++) begin
      r.acc.tag = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : (i == 2) ? 32'h8000_0001
                : 32'h1000 + i;
      r.acc.nvm = (i % 3) != 0;
      r.acc.dirty = i[0];
      r.acc.chance = 1'b1;
      r.typed = 1'b1;
      r.want = miss;
      rows.insert(rows.size(), r);
    end
    // Hit on the extreme tags, then misses that force evictions of every kind.
    r = '0; r.acc.tag = 32'h0; r.acc.nvm = 1'b1; r.acc.dirty = 1'b1; r.acc.chance = 1'b1;
    r.typed = 1'b1; r.want = hit1; rows.insert(rows.size(), r);
    r = '0; r.acc.tag = 32'hFFFF_FFFF; r.typed = 1'b1; r.want = hit1;
    rows.insert(rows.size(), r);
    for (int i = 0; i < 6; i++) begin
      r = '0;
      r.acc.tag = 32'hA000_0000 + i;
      r.acc.nvm = i[0];
      r.acc.dirty = i[1];
      r.acc.chance = 1'b1;
      rows.insert(rows.size(), r);
    end

    for (int i = 0; i < 24; i++) tag_pool[i] = $urandom();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      directed_q.insert(directed_q.size(), rows[i]);
      send(rows[i].acc);
    end

    // Phases sweep the limits, both extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin set_limit(REG_NVM_HIGH, 5'd0); set_limit(REG_NVM_LOW, 5'd16); end
        1: begin set_limit(REG_NVM_HIGH, 5'd31); set_limit(REG_NVM_LOW, 5'd0); end
        2: begin set_limit(REG_NVM_HIGH, 5'd16); set_limit(REG_NVM_LOW, 5'd31); end
        3: begin set_limit(REG_NVM_HIGH, 5'd6); set_limit(REG_NVM_LOW, 5'd10); end
        default: begin
          set_limit(REG_NVM_HIGH, NVM_HIGH_RESET);
          set_limit(REG_NVM_LOW, NVM_LOW_RESET);
        end
      endcase
      for (int k = 0; k < 190; k++) begin
        if (ph == 4 && k >= 90) quiet = 1'b1;
        send(pick_access());
      end
    end
    req.valid <= 1'b0;

    @(posedge clk);
    wait (pending_q.size() == 0);
    @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_q.size() != 0) begin
      errors++;
      $display("ERROR: %0d result beats never arrived", pending_q.size());
    end
    $display("Covered %0d accesses: %0d hits, %0d evictions (%0d dirty), five limit settings.",
             n_acc, n_hit, n_evict, n_dirty_ev);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
